FILE: src/sfp_pkg.sv
// Shared types and constants for the servo status frame parser.
`default_nettype none

package sfp_pkg;

  localparam int unsigned MAX_PARAMS = 16;
  localparam logic [7:0] RETRY_RESET = 8'd200;
  localparam logic [7:0] LEN_OVERHEAD = 8'd2;

  typedef enum logic [1:0] {
    KIND_ARM  = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_TICK = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TIMEOUT = 3'd1,
    ST_TOOBIG  = 3'd2,
    ST_CHKSUM  = 3'd3,
    ST_IDMIS   = 3'd4,
    ST_SERVO   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HDR1 = 3'd1,
    PH_HDR2 = 3'd2,
    PH_ID   = 3'd3,
    PH_LEN  = 3'd4,
    PH_ERR  = 3'd5,
    PH_PAR  = 3'd6,
    PH_CHK  = 3'd7
  } phase_t;

  localparam int unsigned CFG_EXPECTED_ID = 0;
  localparam int unsigned CFG_RETRY_LIMIT = 1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] value_word;
    logic [7:0]  param_count;
    logic [7:0]  servo_error;
    logic [7:0]  frame_id;
    logic [2:0]  status;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

FILE: src/sfp_in_reg.sv
// Input register stage: holds one request until the parser takes it.
`default_nettype none

module sfp_in_reg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]   s_tuser,   // [1:0] kind
  input  wire logic         take,
  output logic              item_vld,
  output sfp_pkg::item_t    item
);

  assign s_tready = !item_vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (s_tready) begin
      item_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.kind    <= s_tuser;
      item.rx_byte <= s_tdata;
    end
  end

endmodule

`default_nettype wire

FILE: src/sfp_parse.sv
// Frame state, config registers and the registered result.
`default_nettype none

module sfp_parse (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [7:0]     cfg_data,
  input  wire logic           item_vld,
  input  wire sfp_pkg::item_t item,
  output logic                take,
  output logic                res_vld,
  output sfp_pkg::result_t    res,
  input  wire logic           res_ready
);

  logic [7:0] expected_id;
  logic [7:0] retry_limit;

  sfp_pkg::phase_t phase, phase_next;
  logic [7:0]  frame_ident, frame_ident_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  error_byte, error_byte_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  params_left, params_left_next;
  logic [15:0] first_word, first_word_next;
  logic [7:0]  wait_ticks, wait_ticks_next;

  logic             fin;
  sfp_pkg::status_t fin_status;
  logic [7:0]       pcount;
  logic [7:0]       len_pcount;
  logic [7:0]       pos;
  logic [7:0]       b;

  assign take = item_vld && (!res_vld || res_ready);
  assign b = item.rx_byte;
  assign pcount = (frame_length >= sfp_pkg::LEN_OVERHEAD) ?
                  frame_length - sfp_pkg::LEN_OVERHEAD : 8'd0;
  assign len_pcount = (b >= sfp_pkg::LEN_OVERHEAD) ? b - sfp_pkg::LEN_OVERHEAD : 8'd0;
  assign pos = pcount - params_left;

  always_comb begin
    phase_next        = phase;
    frame_ident_next  = frame_ident;
    frame_length_next = frame_length;
    error_byte_next   = error_byte;
    running_sum_next  = running_sum;
    params_left_next  = params_left;
    first_word_next   = first_word;
    wait_ticks_next   = wait_ticks;
    fin               = 1'b0;
    fin_status        = sfp_pkg::ST_OK;
    if (take) begin
      unique case (item.kind)
        sfp_pkg::KIND_ARM: begin
          phase_next        = sfp_pkg::PH_HDR1;
          frame_ident_next  = '0;
          frame_length_next = '0;
          error_byte_next   = '0;
          running_sum_next  = '0;
          params_left_next  = '0;
          first_word_next   = '0;
          wait_ticks_next   = '0;
        end
        sfp_pkg::KIND_TICK: begin
          if (phase != sfp_pkg::PH_IDLE) begin
            if (wait_ticks >= retry_limit) begin
              fin        = 1'b1;
              fin_status = sfp_pkg::ST_TIMEOUT;
            end else begin
              wait_ticks_next = wait_ticks + 8'd1;
            end
          end
        end
        sfp_pkg::KIND_BYTE: begin
          unique case (phase)
            sfp_pkg::PH_IDLE: ;
            sfp_pkg::PH_HDR1: phase_next = sfp_pkg::PH_HDR2;
            sfp_pkg::PH_HDR2: phase_next = sfp_pkg::PH_ID;
            sfp_pkg::PH_ID: begin
              frame_ident_next = b;
              running_sum_next = b;
              phase_next       = sfp_pkg::PH_LEN;
            end
            sfp_pkg::PH_LEN: begin
              if (b > 8'(sfp_pkg::MAX_PARAMS)) begin
                fin        = 1'b1;
                fin_status = sfp_pkg::ST_TOOBIG;
              end else begin
                frame_length_next = b;
                running_sum_next  = running_sum + b;
                params_left_next  = len_pcount;
                wait_ticks_next   = '0;
                phase_next        = sfp_pkg::PH_ERR;
              end
            end
            sfp_pkg::PH_ERR: begin
              error_byte_next  = b;
              running_sum_next = running_sum + b;
              phase_next = (params_left != 8'd0) ? sfp_pkg::PH_PAR : sfp_pkg::PH_CHK;
            end
            sfp_pkg::PH_PAR: begin
              if (pos == 8'd0) begin
                first_word_next[7:0] = b;
              end else if (pos == 8'd1) begin
                first_word_next[15:8] = b;
              end
              running_sum_next = running_sum + b;
              params_left_next = params_left - 8'd1;
              if (params_left == 8'd1) begin
                phase_next = sfp_pkg::PH_CHK;
              end
            end
            sfp_pkg::PH_CHK: begin
              fin = 1'b1;
              if (~running_sum != b) begin
                fin_status = sfp_pkg::ST_CHKSUM;
              end else if (frame_ident != expected_id) begin
                fin_status = sfp_pkg::ST_IDMIS;
              end else if (error_byte != 8'd0) begin
                fin_status = sfp_pkg::ST_SERVO;
              end else begin
                fin_status = sfp_pkg::ST_OK;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      if (fin) begin
        phase_next = sfp_pkg::PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= '0;
      retry_limit <= sfp_pkg::RETRY_RESET;
    end else if (cfg_we) begin
      if (cfg_index == 1'(sfp_pkg::CFG_EXPECTED_ID)) begin
        expected_id <= cfg_data;
      end else begin
        retry_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= sfp_pkg::PH_IDLE;
      frame_ident  <= '0;
      frame_length <= '0;
      error_byte   <= '0;
      running_sum  <= '0;
      params_left  <= '0;
      first_word   <= '0;
      wait_ticks   <= '0;
      res_vld      <= 1'b0;
    end else begin
      phase        <= phase_next;
      frame_ident  <= frame_ident_next;
      frame_length <= frame_length_next;
      error_byte   <= error_byte_next;
      running_sum  <= running_sum_next;
      params_left  <= params_left_next;
      first_word   <= first_word_next;
      wait_ticks   <= wait_ticks_next;
      res_vld      <= (res_vld && !res_ready) || fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      res.status      <= fin_status;
      res.frame_id    <= frame_ident;
      res.servo_error <= error_byte;
      res.param_count <= pcount;
      res.value_word  <= first_word;
    end
  end

endmodule

`default_nettype wire

FILE: src/servo_status_frame_parser_unit.sv
// Top level of the servo status frame parser.
//
//  port group   dir  contents
//  s_*          in   requests: tuser kind, tdata received byte
//  m_*          out  one result per finished frame
//  cfg_*        in   register writes: 0 expected id, 1 retry limit
//
// One request per cycle while the result is not stalled. A request is held in
// the input register, then the parse stage updates frame state and loads the
// result register. Result is valid in the cycle after the request is taken.
// Synchronous reset clears frame state, expected id and both valid flags.
// A stalled result holds m_*, the input register keeps taking requests
// until it fills. Reset sets the retry limit to 200.
`default_nettype none

module servo_status_frame_parser_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [7:0]                       s_tdata,  // [7:0] rx_byte
  input  wire logic [1:0]                       s_tuser,  // [1:0] kind
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [2:0] status, [10:3] frame_id, [18:11] servo_error,
  // [26:19] param_count, [42:27] value_word, [47:43] zero
  output logic [sfp_pkg::OUT_DATA_W-1:0]        m_tdata,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_index,
  input  wire logic [7:0]                       cfg_data
);

  logic             take;
  logic             item_vld;
  sfp_pkg::item_t   item;
  sfp_pkg::result_t res;

  sfp_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .take     (take),
    .item_vld (item_vld),
    .item     (item)
  );

  sfp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_vld  (item_vld),
    .item      (item),
    .take      (take),
    .res_vld   (m_tvalid),
    .res       (res),
    .res_ready (m_tready)
  );

  assign m_tdata = sfp_pkg::OUT_DATA_W'(res);

endmodule

`default_nettype wire

FILE: src/sfp_checker.sv
// Port-level checks for the parser top level, bound to it.
`default_nettype none

module sfp_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [sfp_pkg::OUT_DATA_W-1:0] m_tdata
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= 3'(sfp_pkg::ST_SERVO))
    else $error("status code out of range");

  a_ok_no_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == 3'(sfp_pkg::ST_OK) |-> m_tdata[18:11] == 8'd0)
    else $error("ok status with servo error set");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[26:19] <= 8'(sfp_pkg::MAX_PARAMS - 2))
    else $error("parameter count above maximum");

endmodule

bind servo_status_frame_parser_unit sfp_checker u_sfp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
